@@ hw/rtl/csx_pkg.sv @@
// ----------------------------------------------------------------------------
// csx_pkg: shared types and constants of the ChaCha20 stream XOR block
// Holds the word type, the sequencer states, the rotate selections of the
// mixing unit and the configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package csx_pkg;

   localparam int WordW          = 32;
   localparam int CsrDataW       = 64;
   localparam int CsrIdxW        = 3;
   localparam int CSX_DOUBLE_ROUNDS = 10;
   localparam int BlockWords     = 16;

   typedef logic [WordW-1:0] csx_word_type;

   // The four words of the "expand 32-byte k" constant.
   localparam csx_word_type SIGMA [4] = '{
      32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
   };

   typedef enum logic [1:0] {
      ROT16,
      ROT12,
      ROT8,
      ROT7
   } csx_rot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINAL,
      ST_READ,
      ST_DELIVER
   } csx_state_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_KEY_0_7,
      CSR_KEY_8_15,
      CSR_KEY_16_23,
      CSR_KEY_24_31,
      CSR_NONCE_0_7,
      CSR_NONCE_8_11,
      CSR_START_COUNTER
   } csx_csr_type;

endpackage

`default_nettype wire

@@ hw/rtl/csx_ram.sv @@
// ----------------------------------------------------------------------------
// csx_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/csx_mix_unit.sv @@
// ----------------------------------------------------------------------------
// csx_mix_unit: shared add, XOR and rotate unit
// Computes sum = x + y and mix = rotl(z ^ sum, r), one quarter-round step.
// ----------------------------------------------------------------------------
`default_nettype none

module csx_mix_unit (
   input  csx_pkg::csx_word_type x,
   input  csx_pkg::csx_word_type y,
   input  csx_pkg::csx_word_type z,
   input  csx_pkg::csx_rot_type  rot,
   output csx_pkg::csx_word_type sum,
   output csx_pkg::csx_word_type mix
);

   import csx_pkg::*;

   csx_word_type sum_w;
   csx_word_type xor_w;

   always_comb begin
      sum_w = x + y;
      xor_w = z ^ sum_w;
      case (rot)
         ROT16:   mix = {xor_w[15:0], xor_w[31:16]};
         ROT12:   mix = {xor_w[19:0], xor_w[31:20]};
         ROT8:    mix = {xor_w[23:0], xor_w[31:24]};
         ROT7:    mix = {xor_w[24:0], xor_w[31:25]};
         default: mix = xor_w;
      endcase
   end

   assign sum = sum_w;

endmodule

`default_nettype wire

@@ hw/rtl/chacha20_stream_xor_top.sv @@
// ----------------------------------------------------------------------------
// chacha20_stream_xor_top: ChaCha20 keystream XOR, one byte per beat
// A buffered byte is read from the buffer, then sent to the output register;
// a refused byte goes straight to the output. A byte that needs a new block
// first has it made: one quarter-round step, then one feed-forward word, per
// cycle on the shared unit. A beat is done before the next is taken, and a
// result held at the output stalls the next beat. Synchronous reset clears
// the configuration and control registers and leaves the buffer empty.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_stream_xor_top #(
   parameter int DOUBLE_ROUNDS = csx_pkg::CSX_DOUBLE_ROUNDS
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_in_byte,
   input  logic                          req_request_last,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_refused,
   output logic                          rsp_last_out,
   // Configuration write port
   input  logic                          csr_wr_en,
   input  logic [csx_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [csx_pkg::CsrDataW-1:0]  csr_wr_data
);

   import csx_pkg::*;

   // The round counter walks every quarter-round step of every double round.
   // Its low two bits are the step within a quarter round, the next two the
   // column, and bit 4 tells a column round from a diagonal round. During the
   // feed-forward pass its low four bits index the word.
   localparam int RoundSteps = DOUBLE_ROUNDS * 32;
   localparam int RndW       = $clog2(RoundSteps);
   localparam int BufAddrW   = $clog2(BlockWords);

   // Configuration registers.
   logic [63:0]   key0_ff, key0_in;
   logic [63:0]   key1_ff, key1_in;
   logic [63:0]   key2_ff, key2_in;
   logic [63:0]   key3_ff, key3_in;
   logic [63:0]   nonce_lo_ff, nonce_lo_in;
   csx_word_type  nonce_hi_ff, nonce_hi_in;
   csx_word_type  start_ff, start_in;
   logic          restart;
   csx_word_type  restart_counter;

   // Stream state.
   csx_state_type state_ff, state_in;
   csx_word_type  counter_ff, counter_in;
   logic [6:0]    pos_ff, pos_in;
   logic          wrapped_ff, wrapped_in;
   logic [RndW-1:0] rnd_ff, rnd_in;

   // Working words of the block function; the quarter round always acts on
   // column 0 and the rows are rotated round it.
   csx_word_type  work_ff [BlockWords];
   csx_word_type  work_in [BlockWords];
   csx_word_type  init_w  [BlockWords];

   // Item held while it is worked on, and the output register.
   logic [7:0]    hold_byte_ff, hold_byte_in;
   logic          hold_last_ff, hold_last_in;
   logic          hold_refused_ff, hold_refused_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_refused_ff, rsp_refused_in;
   logic          rsp_last_ff, rsp_last_in;

   // Shared unit and keystream buffer.
   csx_word_type  mix_x, mix_y, mix_z, mix_sum, mix_out;
   csx_rot_type   mix_rot;
   logic          buf_wr_en;
   logic          buf_rd_en;
   csx_word_type  buf_rd_data;
   logic [7:0]    ks_byte;

   logic [1:0]    step;
   logic [1:0]    row_amt;
   logic [1:0]    col_sel;
   logic [3:0]    ff_idx;
   logic          out_free;
   logic          last_step;

   assign step      = rnd_ff[1:0];
   assign ff_idx    = rnd_ff[3:0];
   assign last_step = (rnd_ff == RndW'(RoundSteps - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------------
   // Configuration writes. Any write to a known register restarts the
   // stream from the start counter; the start counter itself takes effect
   // in the same write.
   // ---------------------------------------------------------------------
   always_comb begin
      key0_in     = key0_ff;
      key1_in     = key1_ff;
      key2_in     = key2_ff;
      key3_in     = key3_ff;
      nonce_lo_in = nonce_lo_ff;
      nonce_hi_in = nonce_hi_ff;
      start_in    = start_ff;
      restart     = 1'b0;
      if (csr_wr_en) begin
         case (csx_csr_type'(csr_index))
            CSR_KEY_0_7: begin
               key0_in = csr_wr_data;
               restart = 1'b1;
            end
            CSR_KEY_8_15: begin
               key1_in = csr_wr_data;
               restart = 1'b1;
            end
            CSR_KEY_16_23: begin
               key2_in = csr_wr_data;
               restart = 1'b1;
            end
            CSR_KEY_24_31: begin
               key3_in = csr_wr_data;
               restart = 1'b1;
            end
            CSR_NONCE_0_7: begin
               nonce_lo_in = csr_wr_data;
               restart = 1'b1;
            end
            CSR_NONCE_8_11: begin
               nonce_hi_in = csr_wr_data[31:0];
               restart = 1'b1;
            end
            CSR_START_COUNTER: begin
               start_in = csr_wr_data[31:0];
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
      restart_counter = start_in;
   end

   // Initial block state: constant, key, counter and nonce.
   always_comb begin
      init_w[0]  = SIGMA[0];
      init_w[1]  = SIGMA[1];
      init_w[2]  = SIGMA[2];
      init_w[3]  = SIGMA[3];
      init_w[4]  = key0_ff[31:0];
      init_w[5]  = key0_ff[63:32];
      init_w[6]  = key1_ff[31:0];
      init_w[7]  = key1_ff[63:32];
      init_w[8]  = key2_ff[31:0];
      init_w[9]  = key2_ff[63:32];
      init_w[10] = key3_ff[31:0];
      init_w[11] = key3_ff[63:32];
      init_w[12] = counter_ff;
      init_w[13] = nonce_lo_ff[31:0];
      init_w[14] = nonce_lo_ff[63:32];
      init_w[15] = nonce_hi_ff;
   end

   // ---------------------------------------------------------------------
   // Operand selection for the shared unit. Even steps do a += b and
   // d = rotl(d ^ a); odd steps do c += d and b = rotl(b ^ c). In the
   // feed-forward pass the unit adds the initial word to the working word.
   // ---------------------------------------------------------------------
   always_comb begin
      mix_x   = work_ff[ff_idx];
      mix_y   = init_w[ff_idx];
      mix_z   = '0;
      mix_rot = ROT16;
      if (state_ff == ST_ROUND) begin
         if (!step[0]) begin
            mix_x = work_ff[0];
            mix_y = work_ff[4];
            mix_z = work_ff[12];
         end else begin
            mix_x = work_ff[8];
            mix_y = work_ff[12];
            mix_z = work_ff[4];
         end
         case (step)
            2'd0:    mix_rot = ROT16;
            2'd1:    mix_rot = ROT12;
            2'd2:    mix_rot = ROT8;
            default: mix_rot = ROT7;
         endcase
      end
   end

   csx_mix_unit u_mix (
      .x   (mix_x),
      .y   (mix_y),
      .z   (mix_z),
      .rot (mix_rot),
      .sum (mix_sum),
      .mix (mix_out)
   );

   // Keystream buffer: sixteen words, written by the feed-forward pass and
   // read one word per byte.
   csx_ram #(
      .WIDTH (WordW),
      .DEPTH (BlockWords)
   ) u_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (ff_idx),
      .wr_data (mix_sum),
      .rd_en   (buf_rd_en),
      .rd_addr (pos_ff[5:2]),
      .rd_data (buf_rd_data)
   );

   assign ks_byte = buf_rd_data[{pos_ff[1:0], 3'b000} +: 8];

   // ---------------------------------------------------------------------
   // Sequencer. An accepted beat either finds the stream refused, finds a
   // byte waiting in the buffer, or first has a new block made. The result
   // waits in the deliver state until the output register is free.
   // ---------------------------------------------------------------------
   always_comb begin
      csx_word_type tmp [BlockWords];

      state_in        = state_ff;
      counter_in      = counter_ff;
      pos_in          = pos_ff;
      wrapped_in      = wrapped_ff;
      rnd_in          = rnd_ff;
      work_in         = work_ff;
      hold_byte_in    = hold_byte_ff;
      hold_last_in    = hold_last_ff;
      hold_refused_in = hold_refused_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_byte_in     = rsp_byte_ff;
      rsp_refused_in  = rsp_refused_ff;
      rsp_last_in     = rsp_last_ff;
      buf_wr_en       = 1'b0;
      buf_rd_en       = 1'b0;
      tmp             = work_ff;
      row_amt         = 2'd0;
      col_sel         = 2'd0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               hold_byte_in    = req_in_byte;
               hold_last_in    = req_request_last;
               hold_refused_in = wrapped_ff;
               if (wrapped_ff) begin
                  state_in = ST_DELIVER;
               end else if (pos_ff[6]) begin
                  work_in  = init_w;
                  rnd_in   = '0;
                  state_in = ST_ROUND;
               end else begin
                  state_in = ST_READ;
               end
            end
         end

         ST_ROUND: begin
            if (!step[0]) begin
               tmp[0]  = mix_sum;
               tmp[12] = mix_out;
            end else begin
               tmp[8]  = mix_sum;
               tmp[4]  = mix_out;
            end
            if (step == 2'd3) begin
               // Bring the next column to column 0. After the last column
               // of a round the rows are also moved into or out of the
               // diagonal arrangement.
               for (int r = 0; r < 4; r++) begin
                  for (int c = 0; c < 4; c++) begin
                     if (rnd_ff[3:2] == 2'd3) begin
                        row_amt = rnd_ff[4] ? (2'd1 - 2'(r)) : (2'd1 + 2'(r));
                     end else begin
                        row_amt = 2'd1;
                     end
                     col_sel = 2'(c) + row_amt;
                     work_in[4 * r + c] = tmp[{2'(r), col_sel}];
                  end
               end
            end else begin
               work_in = tmp;
            end
            if (last_step) begin
               rnd_in   = '0;
               state_in = ST_FINAL;
            end else begin
               rnd_in = rnd_ff + 1'b1;
            end
         end

         ST_FINAL: begin
            buf_wr_en = 1'b1;
            if (ff_idx == 4'(BlockWords - 1)) begin
               counter_in = counter_ff + 1'b1;
               pos_in     = '0;
               rnd_in     = '0;
               state_in   = ST_READ;
            end else begin
               rnd_in = rnd_ff + 1'b1;
            end
         end

         ST_READ: begin
            buf_rd_en = 1'b1;
            state_in  = ST_DELIVER;
         end

         ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_refused_in = hold_refused_ff;
               rsp_last_in    = hold_last_ff;
               if (hold_refused_ff) begin
                  rsp_byte_in = '0;
               end else begin
                  rsp_byte_in = hold_byte_ff ^ ks_byte;
                  pos_in      = pos_ff + 1'b1;
                  // The block for the last counter value is used in full;
                  // once it runs dry the stream is refused.
                  if ((pos_ff == 7'd63) && (counter_ff == '0)) begin
                     wrapped_in = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (restart) begin
         counter_in = restart_counter;
         pos_in     = 7'd64;
         wrapped_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff      <= '0;
         key1_ff      <= '0;
         key2_ff      <= '0;
         key3_ff      <= '0;
         nonce_lo_ff  <= '0;
         nonce_hi_ff  <= '0;
         start_ff     <= '0;
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         pos_ff       <= 7'd64;
         wrapped_ff   <= 1'b0;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key0_ff      <= key0_in;
         key1_ff      <= key1_in;
         key2_ff      <= key2_in;
         key3_ff      <= key3_in;
         nonce_lo_ff  <= nonce_lo_in;
         nonce_hi_ff  <= nonce_hi_in;
         start_ff     <= start_in;
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         pos_ff       <= pos_in;
         wrapped_ff   <= wrapped_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff         <= work_in;
      hold_byte_ff    <= hold_byte_in;
      hold_last_ff    <= hold_last_in;
      hold_refused_ff <= hold_refused_in;
      rsp_byte_ff     <= rsp_byte_in;
      rsp_refused_ff  <= rsp_refused_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_refused  = rsp_refused_ff;
   assign rsp_last_out = rsp_last_ff;

endmodule

`default_nettype wire

@@ tb/sv/tb_chacha20_stream_xor_top.sv @@
// ----------------------------------------------------------------------------
// tb_chacha20_stream_xor_top: self-checking bench for the ChaCha20 stream XOR
// Drives bytes into the block, works out each expected result with its own
// ChaCha20 keystream generator, and compares every result beat field by
// field. A short table of directed beats comes first. Random phases follow,
// each one after a write to some of the registers or to the unused index.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_xor_top;
   import csx_pkg::*;

   // Run sizes. The watchdog limit is far above the slowest legal run. That
   // run has a fresh block every 64 bytes and on every restart, long receiver
   // stalls, and sender gaps on every beat.
   localparam int ITEM_TARGET  = 1950;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int TAIL_CYCLES  = 400;
   localparam int LONG_HOLD    = 300;

   // Index 7 lies in the index field but names no register.
   localparam logic [CsrIdxW-1:0] CSR_IDX_UNUSED = 3'd7;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       refused;
      logic       last_out;
   } xor_beat_type;

   typedef enum logic {
      ROW_BEAT,
      ROW_CSR
   } row_kind_type;

   typedef enum int {
      SINK_OPEN,
      SINK_HALF,
      SINK_SPARSE,
      SINK_MOSTLY
   } sink_mode_type;

   // One row of the directed table. A beat row can be repeated. When typed is
   // set, the row gives the expected result directly and the generator only
   // advances its state.
   typedef struct packed {
      row_kind_type       kind;
      logic [CsrIdxW-1:0] csr_idx;
      logic [63:0]        csr_data;
      logic [7:0]         data;
      logic               last;
      logic [7:0]         repeat_n;
      logic               typed;
      logic [7:0]         want_byte;
      logic               want_refused;
   } plan_row_type;

   localparam int PLAN_ROWS = 21;

   // The first bytes of the all-zero key, nonce and counter stream are the
   // well-known 76 b8 e0 ad. Once the last block of the counter space is used
   // up, every beat must come back as zero with the refused flag set.
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'h00, 1'b0, 8'd1,  1'b1, 8'h76, 1'b0},
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'h00, 1'b0, 8'd1,  1'b1, 8'hb8, 1'b0},
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'h00, 1'b0, 8'd1,  1'b1, 8'he0, 1'b0},
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'h00, 1'b1, 8'd1,  1'b1, 8'had, 1'b0},
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'hFF, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'hA5, 1'b1, 8'd1,  1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  CSR_IDX_UNUSED,    '1,     8'h00, 1'b0, 8'd0,  1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'h5A, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  CSR_START_COUNTER, 64'hFFFF_FFFF, 8'h00, 1'b0, 8'd0, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'h00, 1'b0, 8'd64, 1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'h5A, 1'b1, 8'd1,  1'b1, 8'h00, 1'b1},
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'hFF, 1'b0, 8'd1,  1'b1, 8'h00, 1'b1},
      '{ROW_CSR,  CSR_NONCE_8_11,    '1,     8'h00, 1'b0, 8'd0,  1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'hC3, 1'b1, 8'd1,  1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  CSR_START_COUNTER, 64'h0,  8'h00, 1'b0, 8'd0,  1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  CSR_KEY_0_7,       '1,     8'h00, 1'b0, 8'd0,  1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'h00, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  CSR_KEY_0_7,       64'h0,  8'h00, 1'b0, 8'd0,  1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  CSR_NONCE_8_11,    64'h0,  8'h00, 1'b0, 8'd0,  1'b0, 8'h00, 1'b0},
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'h00, 1'b0, 8'd1,  1'b1, 8'h76, 1'b0},
      '{ROW_BEAT, CSR_KEY_0_7,       64'h0,  8'h00, 1'b1, 8'd1,  1'b1, 8'hb8, 1'b0}
   };

   // Every input starts at a known value. Reset is held from time zero.
   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [7:0]          req_in_byte      = 8'h00;
   logic                req_request_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [7:0]          rsp_out_byte;
   logic                rsp_refused;
   logic                rsp_last_out;
   logic                csr_wr_en        = 1'b0;
   logic [CsrIdxW-1:0]  csr_index        = '0;
   logic [CsrDataW-1:0] csr_wr_data      = '0;

   chacha20_stream_xor_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_request_last (req_request_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_refused      (rsp_refused),
      .rsp_last_out     (rsp_last_out),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   // -------------------------------------------------------------------------
   // Keystream generator: the bench's own copy of the registers and the
   // stream state.
   // -------------------------------------------------------------------------
   logic [63:0]  key_reg [4];
   logic [63:0]  nonce_lo;
   logic [31:0]  nonce_hi;
   logic [31:0]  start_ctr;
   logic [31:0]  blk_ctr;
   logic [7:0]   ks_buf [64];
   int           ks_pos;
   logic         space_exhausted;

   xor_beat_type awaited_q [$];
   int           beats_sent;
   int           results_checked;
   int           refused_seen;
   int           blocks_made;
   int           csr_writes;
   int           mismatches;
   int           cycle_count;

   function automatic csx_word_type rol32(csx_word_type v, int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // Builds the next 64-byte block: the column and diagonal rounds, then the
   // feed-forward add. The bytes of each word are stored low byte first.
   function automatic void refill_keystream();
      csx_word_type init_w [16];
      csx_word_type w [16];
      csx_word_type sum;
      int a, b, c, d, q;
      for (int i = 0; i < 4; i++) begin
         init_w[i]         = SIGMA[i];
         init_w[4 + 2 * i] = key_reg[i][31:0];
         init_w[5 + 2 * i] = key_reg[i][63:32];
      end
      init_w[12] = blk_ctr;
      init_w[13] = nonce_lo[31:0];
      init_w[14] = nonce_lo[63:32];
      init_w[15] = nonce_hi;
      w = init_w;
      for (int r = 0; r < CSX_DOUBLE_ROUNDS; r++) begin
         for (int col = 0; col < 8; col++) begin
            q = col % 4;
            a = q;
            if (col < 4) begin
               b = 4 + q;
               c = 8 + q;
               d = 12 + q;
            end else begin
               b = 4 + (q + 1) % 4;
               c = 8 + (q + 2) % 4;
               d = 12 + (q + 3) % 4;
            end
            w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 16);
            w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 12);
            w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 8);
            w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 7);
         end
      end
      for (int i = 0; i < 16; i++) begin
         sum = w[i] + init_w[i];
         for (int k = 0; k < 4; k++)
            ks_buf[4 * i + k] = sum[8 * k +: 8];
      end
      blk_ctr = blk_ctr + 32'd1;
      ks_pos  = 0;
      blocks_made++;
   endfunction

   function automatic xor_beat_type cipher_step(logic [7:0] data, logic last);
      xor_beat_type res;
      res.last_out = last;
      if (space_exhausted) begin
         res.out_byte = 8'h00;
         res.refused  = 1'b1;
         return res;
      end
      if (ks_pos >= 64)
         refill_keystream();
      res.out_byte = data ^ ks_buf[ks_pos];
      res.refused  = 1'b0;
      ks_pos++;
      // The counter has wrapped to zero only after the block for the top
      // counter value was made, so its last byte closes the stream.
      if (ks_pos >= 64 && blk_ctr == 32'd0)
         space_exhausted = 1'b1;
      return res;
   endfunction

   function automatic void restart_stream();
      blk_ctr         = start_ctr;
      ks_pos          = 64;
      space_exhausted = 1'b0;
   endfunction

   // A write to an unused index changes nothing, and the stream carries on.
   function automatic void apply_csr(logic [CsrIdxW-1:0] idx, logic [63:0] data);
      case (idx)
         CSR_KEY_0_7, CSR_KEY_8_15, CSR_KEY_16_23, CSR_KEY_24_31: key_reg[idx] = data;
         CSR_NONCE_0_7:     nonce_lo  = data;
         CSR_NONCE_8_11:    nonce_hi  = data[31:0];
         CSR_START_COUNTER: start_ctr = data[31:0];
         default:           return;
      endcase
      restart_stream();
   endfunction

   // Register values lean towards the extremes. The start counter is often
   // placed just below the end of the counter space. The upper half of the
   // 32-bit registers is random, so a value that is cut short shows up.
   function automatic logic [63:0] pick_csr_value(int idx);
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: begin
            if (idx == CSR_START_COUNTER) begin
               case ($urandom_range(0, 3))
                  0: v[31:0] = 32'hFFFF_FFFF;
                  1: v[31:0] = 32'hFFFF_FFFE;
                  2: v[31:0] = $urandom_range(0, 3);
                  default: ;
               endcase
            end
            return v;
         end
      endcase
   endfunction

   task automatic log_mismatch(string msg);
      $display("mismatch @%0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   // -------------------------------------------------------------------------
   // Sender tasks. Each one starts in the time step of a rising edge, so every
   // request signal gets at most one nonblocking update per step.
   // -------------------------------------------------------------------------
   task automatic offer_byte(logic [7:0] b, logic last, logic typed,
                             xor_beat_type typed_val);
      xor_beat_type predicted;
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_request_last <= last;
      do @(posedge clock); while (!req_ready);
      predicted = cipher_step(b, last);
      awaited_q.push_back(typed ? typed_val : predicted);
      beats_sent++;
   endtask

   task automatic pause_sender(int n);
      if (n == 0)
         return;
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Holds the sender off until every result that was asked for has arrived.
   // Each beat gives exactly one result, so an empty queue means the block
   // is idle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_q.size() != 0)
         @(posedge clock);
   endtask

   // The write takes effect at the next edge. The caller lowers the enable
   // once the last write of a group is done.
   task automatic csr_write(logic [CsrIdxW-1:0] idx, logic [63:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      apply_csr(idx, data);
      csr_writes++;
      @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_q.size());
         $display("status: fail");
         $finish;
      end
   end

   // Result checker. Every accepted result beat is compared with the oldest
   // expectation.
   always @(posedge clock) begin
      xor_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (rsp_refused)
            refused_seen++;
         if (awaited_q.size() == 0) begin
            log_mismatch($sformatf("result %02h arrived with nothing expected",
                                   rsp_out_byte));
         end else begin
            want = awaited_q.pop_front();
            if (rsp_out_byte !== want.out_byte)
               log_mismatch($sformatf("out_byte %02h, expected %02h",
                                      rsp_out_byte, want.out_byte));
            if (rsp_refused !== want.refused)
               log_mismatch($sformatf("refused %b, expected %b",
                                      rsp_refused, want.refused));
            if (rsp_last_out !== want.last_out)
               log_mismatch($sformatf("last_out %b, expected %b",
                                      rsp_last_out, want.last_out));
         end
      end
   end

   // Receiver. It keeps its own pattern of stretches: always ready, ready
   // half the time, ready rarely, and ready most of the time. Now and then,
   // between stretches, it refuses all results for a long while. The sender
   // keeps offering bytes meanwhile, so the block fills up and has to stall
   // its input.
   initial begin
      sink_mode_type mode;
      int            seg_len;
      int            next_hold = 300;
      forever begin
         if (results_checked >= next_hold) begin
            next_hold += 600;
            repeat (LONG_HOLD) begin
               @(posedge clock);
               rsp_ready <= 1'b0;
            end
         end
         mode    = sink_mode_type'($urandom_range(0, 3));
         seg_len = $urandom_range(10, 150);
         repeat (seg_len) begin
            @(posedge clock);
            case (mode)
               SINK_OPEN:   rsp_ready <= 1'b1;
               SINK_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
               SINK_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Sender and sequencing of the run.
   initial begin
      plan_row_type row;
      int           phase_count;
      int           phase_len;
      int           sent_in_phase;
      int           burst;
      logic         wrote;

      // Generator state after reset: all registers zero and the buffer empty,
      // so the first byte makes the first block.
      for (int i = 0; i < 4; i++)
         key_reg[i] = '0;
      nonce_lo  = '0;
      nonce_hi  = '0;
      start_ctr = '0;
      restart_stream();
      phase_count = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Register rows wait until the block has delivered
      // everything, since the registers are only written while it is idle.
      for (int r = 0; r < PLAN_ROWS; r++) begin
         row = directed_plan[r];
         if (row.kind == ROW_CSR) begin
            drain_results();
            csr_write(row.csr_idx, row.csr_data);
         end else begin
            if (csr_wr_en)
               csr_wr_en <= 1'b0;
            repeat (row.repeat_n)
               offer_byte(row.data, row.last, row.typed,
                          xor_beat_type'{row.want_byte, row.want_refused, row.last});
         end
      end

      // Random phases. Each one starts from an idle block with a new register
      // setting. The first phase sets every register to all ones. Sometimes
      // only the unused index is written, and then the stream must carry on
      // from where it stopped.
      while (beats_sent < ITEM_TARGET) begin
         drain_results();
         if (phase_count == 0) begin
            for (int i = 0; i <= CSR_START_COUNTER; i++)
               csr_write(i[CsrIdxW-1:0], '1);
         end else if ($urandom_range(0, 7) == 0) begin
            csr_write(CSR_IDX_UNUSED, {$urandom, $urandom});
         end else begin
            wrote = 1'b0;
            for (int i = 0; i <= CSR_START_COUNTER; i++) begin
               if ($urandom_range(0, 1) == 1 || (i == CSR_START_COUNTER && !wrote)) begin
                  csr_write(i[CsrIdxW-1:0], pick_csr_value(i));
                  wrote = 1'b1;
               end
            end
         end
         csr_wr_en <= 1'b0;

         // Near the end of the counter space the phase runs long enough to
         // reach refusal, even from the second-to-last counter value.
         phase_len = (start_ctr >= 32'hFFFF_FFFE) ? $urandom_range(140, 220)
                                                  : $urandom_range(8, 180);
         sent_in_phase = 0;
         while (sent_in_phase < phase_len) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent_in_phase < phase_len; k++) begin
               offer_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0),
                          1'b0, '0);
               sent_in_phase++;
            end
            case ($urandom_range(0, 15))
               0:          drain_results();
               1, 2, 3, 4: ;
               default:    pause_sender($urandom_range(1, 12));
            endcase
         end
         phase_count++;
      end

      // Wind-down. Every result must have come, and nothing more may follow
      // while the bench waits out the tail.
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d bytes in %0d random phases, %0d results checked (%0d refused)",
               beats_sent, phase_count, results_checked, refused_seen);
      $display("%0d keystream blocks predicted, %0d register writes, %0d mismatches",
               blocks_made, csr_writes, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
